@@ rtl/poisson_disk_rejection_filter_core_assert.svh @@
// Assertion macros shared by the filter modules.
// Both sample on the rising edge of clk and are quiet while arst_n is low.
`ifndef POISSON_DISK_REJECTION_FILTER_CORE_ASSERT_SVH
`define POISSON_DISK_REJECTION_FILTER_CORE_ASSERT_SVH

// Property must hold at every edge out of reset.
`define PDRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define PDRF_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/pdrf_pkg.sv @@
package pdrf_pkg;

	localparam int SPACING_BITS = 23;
	localparam int ACC_BITS     = 11;
	localparam int CNT_BITS     = 17;
	localparam int IDX_BITS     = 16;
	localparam int KEY_BITS     = 64;
	localparam int VERDICT_BITS = 3;
	localparam int SQ_BITS      = 2 * SPACING_BITS;
	localparam int SUM_BITS     = SQ_BITS + 2;

	localparam int OUT_RAW_W  = IDX_BITS + KEY_BITS + ACC_BITS + 4 * CNT_BITS;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

	localparam int CFG_ADDR_BITS = 5;

	localparam logic [2:0] REG_MAX_ACCEPTED  = 3'd0;
	localparam logic [2:0] REG_DEFAULT_SP    = 3'd1;
	localparam logic [2:0] REG_USE_LOCAL_SP  = 3'd2;
	localparam logic [2:0] REG_USE_DENSITY   = 3'd3;
	localparam logic [2:0] REG_USE_MASK      = 3'd4;

	localparam logic [ACC_BITS-1:0]     MAX_ACCEPTED_RST = 11'd1024;
	localparam logic [SPACING_BITS-1:0] DEFAULT_SP_RST   = 23'd4096;

	localparam logic [VERDICT_BITS-1:0] V_ACCEPT      = 3'd0;
	localparam logic [VERDICT_BITS-1:0] V_DENSITY     = 3'd1;
	localparam logic [VERDICT_BITS-1:0] V_MASK        = 3'd2;
	localparam logic [VERDICT_BITS-1:0] V_CONFLICT    = 3'd3;
	localparam logic [VERDICT_BITS-1:0] V_LIMIT       = 3'd4;
	localparam logic [VERDICT_BITS-1:0] V_BAD_SPACING = 3'd5;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clear;
	} scan_ctl_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} scan_sts_t;

endpackage

@@ rtl/pdrf_scan.sv @@
`include "poisson_disk_rejection_filter_core_assert.svh"

module pdrf_scan #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 24,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pdrf_pkg::scan_ctl_t                 ctl,
	input  logic [AW-1:0]                       addr,
	input  logic signed [COORD_BITS-1:0]        cand_x,
	input  logic signed [COORD_BITS-1:0]        cand_y,
	input  logic signed [COORD_BITS-1:0]        cand_z,
	input  logic [pdrf_pkg::SPACING_BITS-1:0]   cand_sp,
	output pdrf_pkg::scan_sts_t                 sts
);
	import pdrf_pkg::*;

	localparam int WW = 3 * COORD_BITS + SPACING_BITS;
	localparam int DW = (COORD_BITS + 1 > SPACING_BITS) ? COORD_BITS + 1 : SPACING_BITS;

	logic [WW-1:0] mem [MAX_POINTS];
	logic [WW-1:0] rd_s1;
	logic          v_s1, v_s2, v_s3;

	logic signed [COORD_BITS-1:0] st_x, st_y, st_z;
	logic [SPACING_BITS-1:0]      st_sp, md;
	logic signed [COORD_BITS:0]   diff_x, diff_y, diff_z;
	logic [COORD_BITS:0]          mag_x, mag_y, mag_z;
	logic                         near;

	logic [SPACING_BITS-1:0] dx_s2, dy_s2, dz_s2, md_s2;
	logic                    near_s2;
	logic [SQ_BITS-1:0]      sqx_s3, sqy_s3, sqz_s3, md2_s3;
	logic                    near_s3;
	logic [SUM_BITS-1:0]     dist2;
	logic                    hit_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= {cand_sp, cand_z, cand_y, cand_x};
		end
		if (ctl.rd) begin
			rd_s1 <= mem[addr];
		end
	end

	assign st_x  = rd_s1[COORD_BITS-1:0];
	assign st_y  = rd_s1[2*COORD_BITS-1:COORD_BITS];
	assign st_z  = rd_s1[3*COORD_BITS-1:2*COORD_BITS];
	assign st_sp = rd_s1[WW-1:3*COORD_BITS];

	always_comb begin
		diff_x = (COORD_BITS+1)'(cand_x) - (COORD_BITS+1)'(st_x);
		diff_y = (COORD_BITS+1)'(cand_y) - (COORD_BITS+1)'(st_y);
		diff_z = (COORD_BITS+1)'(cand_z) - (COORD_BITS+1)'(st_z);
		mag_x  = diff_x[COORD_BITS] ? unsigned'(-diff_x) : unsigned'(diff_x);
		mag_y  = diff_y[COORD_BITS] ? unsigned'(-diff_y) : unsigned'(diff_y);
		mag_z  = diff_z[COORD_BITS] ? unsigned'(-diff_z) : unsigned'(diff_z);
		md     = (cand_sp > st_sp) ? cand_sp : st_sp;
		// outside the box on any axis cannot conflict
		near   = (DW'(mag_x) < DW'(md)) && (DW'(mag_y) < DW'(md)) && (DW'(mag_z) < DW'(md));
	end

	// narrow deltas are exact whenever near holds
	always_ff @(posedge clk) begin
		dx_s2   <= SPACING_BITS'(mag_x);
		dy_s2   <= SPACING_BITS'(mag_y);
		dz_s2   <= SPACING_BITS'(mag_z);
		md_s2   <= md;
		near_s2 <= near;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		sqz_s3  <= dz_s2 * dz_s2;
		md2_s3  <= md_s2 * md_s2;
		near_s3 <= near_s2;
	end

	assign dist2 = SUM_BITS'(sqx_s3) + SUM_BITS'(sqy_s3) + SUM_BITS'(sqz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			v_s1 <= ctl.rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctl.clear) begin
				hit_q <= 1'b0;
			end else if (v_s3 && near_s3 && (dist2 < SUM_BITS'(md2_s3))) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign sts.busy = v_s1 | v_s2 | v_s3;
	assign sts.hit  = hit_q;

	`PDRF_NEVER(a_rd_wr_excl, ctl.rd && ctl.wr, "store read and write in the same cycle")
	`PDRF_ASSERT(a_clear_idle, ctl.clear |-> !(v_s1 || v_s2 || v_s3), "hit cleared mid scan")

endmodule

@@ rtl/poisson_disk_rejection_filter_core.sv @@
// Flow: IDLE, EVAL, then SCAN and DRAIN when a store scan is needed, then DONE.
// No scan is needed on limit, bad spacing, gate reject or an empty store.
// Input is taken only in IDLE, after the last result is committed; the single store
// read port, one entry per cycle, sets the scan length (up to MAX_POINTS - 1 reads).
// Reset: counters, batch index and handshake state clear; registers take their defaults.
// The point store has no reset; only entries written in the current batch are read.
`include "poisson_disk_rejection_filter_core_assert.svh"

module poisson_disk_rejection_filter_core #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 24,
	parameter int PROB_BITS  = 16,
	localparam int IN_RAW_W  = 3 * COORD_BITS + 4 * PROB_BITS + 2 + pdrf_pkg::SPACING_BITS
		+ pdrf_pkg::KEY_BITS,
	localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// pos_x, pos_y, pos_z, density_draw, mask_draw, density_accept, mask_accept,
	// min_spacing, sample_key
	input  logic [IN_W-1:0]                      s_tdata,
	// new_batch
	input  logic [0:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// cand_index, key_out, accepted_total, considered_total, density_rejects,
	// mask_rejects, conflict_rejects
	output logic [pdrf_pkg::OUT_DATA_W-1:0]      m_tdata,
	// verdict
	output logic [pdrf_pkg::VERDICT_BITS-1:0]    m_tuser,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pdrf_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import pdrf_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int XW = AW + ACC_BITS;
	localparam int PB = PROB_BITS;

	localparam int O_X   = 0;
	localparam int O_Y   = COORD_BITS;
	localparam int O_Z   = 2 * COORD_BITS;
	localparam int O_DD  = 3 * COORD_BITS;
	localparam int O_MD  = O_DD + PB;
	localparam int O_DA  = O_MD + PB;
	localparam int O_MA  = O_DA + PB + 1;
	localparam int O_LS  = O_MA + PB + 1;
	localparam int O_KEY = O_LS + SPACING_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [PB:0] PROB_ONE = {1'b1, {PB{1'b0}}};

	// configuration
	logic [ACC_BITS-1:0]     max_acc_q;
	logic [SPACING_BITS-1:0] def_sp_q;
	logic                    use_local_q, use_den_q, use_mask_q;
	logic                    cfg_wr;

	// candidate held for the whole item
	logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic [PB-1:0]                dd_q, mdr_q;
	logic [PB:0]                  da_q, ma_q;
	logic [SPACING_BITS-1:0]      sp_q;
	logic [KEY_BITS-1:0]          key_q;
	logic [IDX_BITS-1:0]          idx_q;
	logic [VERDICT_BITS-1:0]      verdict_q;

	// batch counters
	logic [ACC_BITS-1:0] acc_q;
	logic [CNT_BITS-1:0] cons_q, den_q, msk_q, cnf_q;
	logic [IDX_BITS-1:0] nidx_q, nidx_base;

	logic [2:0]          state_q;
	logic [ACC_BITS-1:0] scan_cnt_q;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic [VERDICT_BITS-1:0] out_verdict_q;

	logic                    s_xfer, commit, at_limit, den_fail, msk_fail;
	logic [PB:0]             dacc, macc;
	logic [VERDICT_BITS-1:0] eval_verdict, final_verdict;
	logic [ACC_BITS-1:0]     acc_n;
	logic [CNT_BITS-1:0]     cons_n, den_n, msk_n, cnf_n;
	logic [XW-1:0]           addr_ext;

	scan_ctl_t scan_ctl;
	scan_sts_t scan_sts;

	function automatic logic [CNT_BITS-1:0] sat_cnt(input logic [CNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_acc_q   <= MAX_ACCEPTED_RST;
			def_sp_q    <= DEFAULT_SP_RST;
			use_local_q <= 1'b0;
			use_den_q   <= 1'b0;
			use_mask_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MAX_ACCEPTED: max_acc_q   <= pwdata[ACC_BITS-1:0];
				REG_DEFAULT_SP:   def_sp_q    <= pwdata[SPACING_BITS-1:0];
				REG_USE_LOCAL_SP: use_local_q <= pwdata[0];
				REG_USE_DENSITY:  use_den_q   <= pwdata[0];
				REG_USE_MASK:     use_mask_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MAX_ACCEPTED: prdata = 32'(max_acc_q);
			REG_DEFAULT_SP:   prdata = 32'(def_sp_q);
			REG_USE_LOCAL_SP: prdata = 32'(use_local_q);
			REG_USE_DENSITY:  prdata = 32'(use_den_q);
			REG_USE_MASK:     prdata = 32'(use_mask_q);
			default:          prdata = 32'd0;
		endcase
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid & s_tready;
	assign nidx_base = s_tuser[0] ? '0 : nidx_q;

	// gate and limit decisions on the held candidate
	always_comb begin
		at_limit = (int'(acc_q) >= int'(max_acc_q)) || (int'(acc_q) >= MAX_POINTS);
		dacc     = (use_den_q && da_q <= PROB_ONE) ? da_q : PROB_ONE;
		macc     = (use_mask_q && ma_q <= PROB_ONE) ? ma_q : PROB_ONE;
		den_fail = {1'b0, dd_q} >= dacc;
		msk_fail = {1'b0, mdr_q} >= macc;
		if (at_limit) begin
			eval_verdict = V_LIMIT;
		end else if (sp_q == '0) begin
			eval_verdict = V_BAD_SPACING;
		end else if (den_fail) begin
			eval_verdict = V_DENSITY;
		end else if (msk_fail) begin
			eval_verdict = V_MASK;
		end else begin
			eval_verdict = V_ACCEPT;
		end
	end

	assign final_verdict = (verdict_q == V_ACCEPT && scan_sts.hit) ? V_CONFLICT : verdict_q;
	assign commit        = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		acc_n  = acc_q;
		cons_n = cons_q;
		den_n  = den_q;
		msk_n  = msk_q;
		cnf_n  = cnf_q;
		if (final_verdict != V_LIMIT && final_verdict != V_BAD_SPACING) begin
			cons_n = sat_cnt(cons_q);
		end
		case (final_verdict)
			V_ACCEPT:   acc_n = (&acc_q) ? acc_q : acc_q + 1'b1;
			V_DENSITY:  den_n = sat_cnt(den_q);
			V_MASK:     msk_n = sat_cnt(msk_q);
			V_CONFLICT: cnf_n = sat_cnt(cnf_q);
			default: ;
		endcase
	end

	// store access: scan reads walk up from zero, the accept writes at the fill level
	always_comb begin
		scan_ctl.rd    = (state_q == ST_SCAN);
		scan_ctl.wr    = commit && (final_verdict == V_ACCEPT);
		scan_ctl.clear = (state_q == ST_EVAL);
		addr_ext       = scan_ctl.wr ? XW'(acc_q) : XW'(scan_cnt_q);
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cx_q  <= s_tdata[O_X +: COORD_BITS];
			cy_q  <= s_tdata[O_Y +: COORD_BITS];
			cz_q  <= s_tdata[O_Z +: COORD_BITS];
			dd_q  <= s_tdata[O_DD +: PB];
			mdr_q <= s_tdata[O_MD +: PB];
			da_q  <= s_tdata[O_DA +: PB + 1];
			ma_q  <= s_tdata[O_MA +: PB + 1];
			sp_q  <= use_local_q ? s_tdata[O_LS +: SPACING_BITS] : def_sp_q;
			key_q <= s_tdata[O_KEY +: KEY_BITS];
			idx_q <= nidx_base;
		end
		if (state_q == ST_EVAL) begin
			verdict_q <= eval_verdict;
		end
		if (commit) begin
			out_verdict_q <= final_verdict;
			out_data_q    <= {{OUT_PAD_W{1'b0}}, cnf_n, msk_n, den_n, cons_n, acc_n,
				key_q, idx_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
			acc_q      <= '0;
			cons_q     <= '0;
			den_q      <= '0;
			msk_q      <= '0;
			cnf_q      <= '0;
			nidx_q     <= '0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						if (s_tuser[0]) begin
							acc_q  <= '0;
							cons_q <= '0;
							den_q  <= '0;
							msk_q  <= '0;
							cnf_q  <= '0;
						end
						nidx_q  <= nidx_base + 1'b1;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					scan_cnt_q <= '0;
					if (eval_verdict == V_ACCEPT && acc_q != '0) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == acc_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold until the last compare has landed in the hit flag
					if (!scan_sts.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						acc_q      <= acc_n;
						cons_q     <= cons_n;
						den_q      <= den_n;
						msk_q      <= msk_n;
						cnf_q      <= cnf_n;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_verdict_q;

	pdrf_scan #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.addr    (addr_ext[AW-1:0]),
		.cand_x  (cx_q),
		.cand_y  (cy_q),
		.cand_z  (cz_q),
		.cand_sp (sp_q),
		.sts     (scan_sts)
	);

	`PDRF_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (scan_cnt_q < acc_q), "scan beyond fill level")
	`PDRF_ASSERT(a_done_drained, (state_q == ST_DONE) |-> !scan_sts.busy, "verdict before scan drained")
	`PDRF_ASSERT(a_fill_bound, int'(acc_q) <= MAX_POINTS, "accepted count beyond store depth")
	`PDRF_ASSERT(a_store_on_accept, scan_ctl.wr |-> (verdict_q == V_ACCEPT && !scan_sts.hit), "store written for a rejected candidate")

endmodule

@@ test/tb_poisson_disk_rejection_filter_core.sv @@
module tb_poisson_disk_rejection_filter_core;

	import pdrf_pkg::*;

	localparam int IN_W        = ((3 * 24 + 4 * 16 + 2 + SPACING_BITS + KEY_BITS + 7) / 8) * 8;
	localparam int STORE_DEPTH = 1024;
	localparam int PROB_ONE    = 65536;
	localparam int CNT_TOP     = (1 << CNT_BITS) - 1;
	localparam int ACC_TOP     = (1 << ACC_BITS) - 1;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 200;

	typedef struct {
		bit                 new_batch;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [15:0]        density_draw;
		logic [15:0]        mask_draw;
		logic [16:0]        density_accept;
		logic [16:0]        mask_accept;
		logic [22:0]        min_spacing;
		logic [63:0]        sample_key;
	} candidate_t;

	// result fields from the lowest bit up: index, key, accepted, considered, three rejects
	typedef struct packed {
		logic [OUT_PAD_W-1:0]    pad;
		logic [CNT_BITS-1:0]     conflict_rejects;
		logic [CNT_BITS-1:0]     mask_rejects;
		logic [CNT_BITS-1:0]     density_rejects;
		logic [CNT_BITS-1:0]     considered_total;
		logic [ACC_BITS-1:0]     accepted_total;
		logic [KEY_BITS-1:0]     key_out;
		logic [IDX_BITS-1:0]     cand_index;
	} tally_t;

	typedef struct packed {
		logic [VERDICT_BITS-1:0] verdict;
		tally_t                  tally;
	} outcome_t;

	class filter_scoreboard;
		int unsigned       limit_cfg   = 1024;
		int unsigned       spacing_cfg = 4096;
		bit                local_cfg;
		bit                density_cfg;
		bit                mask_cfg;
		longint            pt_x[STORE_DEPTH];
		longint            pt_y[STORE_DEPTH];
		longint            pt_z[STORE_DEPTH];
		longint unsigned   pt_sp[STORE_DEPTH];
		int unsigned       accepted;
		int unsigned       considered;
		int unsigned       density_hits;
		int unsigned       mask_hits;
		int unsigned       conflict_hits;
		bit [IDX_BITS-1:0] next_index;
		outcome_t          verdicts_due[$];
		int                errors;

		function void set_reg(logic [2:0] which, logic [31:0] value);
			case (which)
				REG_MAX_ACCEPTED: limit_cfg = value[ACC_BITS-1:0];
				REG_DEFAULT_SP:   spacing_cfg = value[SPACING_BITS-1:0];
				REG_USE_LOCAL_SP: local_cfg = value[0];
				REG_USE_DENSITY:  density_cfg = value[0];
				REG_USE_MASK:     mask_cfg = value[0];
				default: ;
			endcase
		endfunction

		function int unsigned bump(int unsigned count, int unsigned top);
			return count < top ? count + 1 : top;
		endfunction

		// closer than the larger spacing to any point stored in this batch
		function bit too_close(longint x, longint y, longint z, longint unsigned sp);
			longint unsigned md, dx, dy, dz;
			for (int i = 0; i < accepted && i < STORE_DEPTH; i++) begin
				md = sp > pt_sp[i] ? sp : pt_sp[i];
				dx = x >= pt_x[i] ? x - pt_x[i] : pt_x[i] - x;
				dy = y >= pt_y[i] ? y - pt_y[i] : pt_y[i] - y;
				dz = z >= pt_z[i] ? z - pt_z[i] : pt_z[i] - z;
				if (dx < md && dy < md && dz < md && dx * dx + dy * dy + dz * dz < md * md)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_candidate(candidate_t c);
			outcome_t        o;
			int unsigned     dacc, macc, lim;
			longint unsigned sp;
			if (c.new_batch) begin
				accepted = 0;
				considered = 0;
				density_hits = 0;
				mask_hits = 0;
				conflict_hits = 0;
				next_index = '0;
			end
			o = '0;
			o.tally.cand_index = next_index;
			next_index++;
			dacc = c.density_accept > PROB_ONE ? PROB_ONE : c.density_accept;
			macc = c.mask_accept > PROB_ONE ? PROB_ONE : c.mask_accept;
			if (!density_cfg)
				dacc = PROB_ONE;
			if (!mask_cfg)
				macc = PROB_ONE;
			sp = local_cfg ? c.min_spacing : spacing_cfg;
			lim = limit_cfg < STORE_DEPTH ? limit_cfg : STORE_DEPTH;
			if (accepted >= lim) begin
				o.verdict = V_LIMIT;
			end else if (sp == 0) begin
				o.verdict = V_BAD_SPACING;
			end else begin
				considered = bump(considered, CNT_TOP);
				if (c.density_draw >= dacc) begin
					o.verdict = V_DENSITY;
					density_hits = bump(density_hits, CNT_TOP);
				end else if (c.mask_draw >= macc) begin
					o.verdict = V_MASK;
					mask_hits = bump(mask_hits, CNT_TOP);
				end else if (too_close(c.pos_x, c.pos_y, c.pos_z, sp)) begin
					o.verdict = V_CONFLICT;
					conflict_hits = bump(conflict_hits, CNT_TOP);
				end else begin
					o.verdict = V_ACCEPT;
					if (accepted < STORE_DEPTH) begin
						pt_x[accepted] = c.pos_x;
						pt_y[accepted] = c.pos_y;
						pt_z[accepted] = c.pos_z;
						pt_sp[accepted] = sp;
					end
					accepted = bump(accepted, ACC_TOP);
				end
			end
			o.tally.key_out = c.sample_key;
			o.tally.accepted_total = accepted[ACC_BITS-1:0];
			o.tally.considered_total = considered[CNT_BITS-1:0];
			o.tally.density_rejects = density_hits[CNT_BITS-1:0];
			o.tally.mask_rejects = mask_hits[CNT_BITS-1:0];
			o.tally.conflict_rejects = conflict_hits[CNT_BITS-1:0];
			verdicts_due.insert(verdicts_due.size(), o);
		endfunction

		function void compare(string what, longint unsigned want, longint unsigned got,
				logic [63:0] key);
			if (want != got) begin
				errors++;
				if (errors <= 10)
					$display("mismatch in %s for key %h: expected %0d, got %0d",
						what, key, want, got);
			end
		endfunction

		function void check_result(logic [VERDICT_BITS-1:0] verdict, tally_t got);
			outcome_t want;
			if (verdicts_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with no candidate outstanding: verdict %0d key %h",
						verdict, got.key_out);
				return;
			end
			want = verdicts_due.pop_front();
			compare("verdict", want.verdict, verdict, want.tally.key_out);
			compare("cand_index", want.tally.cand_index, got.cand_index,
				want.tally.key_out);
			compare("key_out", want.tally.key_out, got.key_out, want.tally.key_out);
			compare("accepted_total", want.tally.accepted_total, got.accepted_total,
				want.tally.key_out);
			compare("considered_total", want.tally.considered_total, got.considered_total,
				want.tally.key_out);
			compare("density_rejects", want.tally.density_rejects, got.density_rejects,
				want.tally.key_out);
			compare("mask_rejects", want.tally.mask_rejects, got.mask_rejects,
				want.tally.key_out);
			compare("conflict_rejects", want.tally.conflict_rejects, got.conflict_rejects,
				want.tally.key_out);
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_W-1:0]           s_tdata = '0;
	logic [0:0]                s_tuser = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]     m_tdata;
	logic [VERDICT_BITS-1:0]   m_tuser;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0]  paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;

	filter_scoreboard sb;
	bit               calm;
	int               hold_request;
	int               stall_left;
	int               quiet_cycles;
	int               prev_x, prev_y, prev_z;

	poisson_disk_rejection_filter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hold_request > 0) begin
				stall_left = hold_request - 1;
				hold_request = 0;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, tally_t'(m_tdata));
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [16:0] acceptance();
		case ($urandom_range(0, 5))
			0, 1: return 17'(PROB_ONE);
			2: return 17'd0;
			3: return 17'($urandom_range(PROB_ONE + 1, 131071));
			default: return 17'($urandom_range(0, PROB_ONE));
		endcase
	endfunction

	function automatic candidate_t random_candidate(input bit first);
		candidate_t  c;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		c.new_batch = first || ($urandom_range(0, 15) == 0);
		if (pick < 2) begin
			c.pos_x = 24'($urandom);
			c.pos_y = 24'($urandom);
			c.pos_z = 24'($urandom);
		end else if (pick < 5) begin
			// land near the last candidate to probe the spacing boundary
			c.pos_x = 24'(prev_x + int'($urandom_range(0, 12000)) - 6000);
			c.pos_y = 24'(prev_y + int'($urandom_range(0, 12000)) - 6000);
			c.pos_z = 24'(prev_z + int'($urandom_range(0, 12000)) - 6000);
		end else begin
			c.pos_x = 24'(int'($urandom_range(0, 40000)) - 20000);
			c.pos_y = 24'(int'($urandom_range(0, 40000)) - 20000);
			c.pos_z = 24'(int'($urandom_range(0, 40000)) - 20000);
		end
		prev_x = int'(c.pos_x);
		prev_y = int'(c.pos_y);
		prev_z = int'(c.pos_z);
		c.density_draw = 16'($urandom);
		c.mask_draw = 16'($urandom);
		c.density_accept = acceptance();
		c.mask_accept = acceptance();
		case ($urandom_range(0, 15))
			0: c.min_spacing = '0;
			1: c.min_spacing = 23'h7fffff;
			2: c.min_spacing = 23'($urandom);
			3: c.min_spacing = 23'd1;
			default: c.min_spacing = 23'($urandom_range(1000, 9000));
		endcase
		c.sample_key = {$urandom, $urandom};
		return c;
	endfunction

	function automatic candidate_t make_item(input bit nb, input int x, input int y,
			input int z, input int unsigned ddraw, input int unsigned mdraw,
			input int unsigned dacc, input int unsigned macc, input int unsigned sp);
		candidate_t c;
		c.new_batch = nb;
		c.pos_x = 24'(x);
		c.pos_y = 24'(y);
		c.pos_z = 24'(z);
		c.density_draw = 16'(ddraw);
		c.mask_draw = 16'(mdraw);
		c.density_accept = 17'(dacc);
		c.mask_accept = 17'(macc);
		c.min_spacing = 23'(sp);
		c.sample_key = {$urandom, $urandom};
		return c;
	endfunction

	task automatic send_item(input candidate_t c);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= c.new_batch;
		s_tdata <= IN_W'({c.sample_key, c.min_spacing, c.mask_accept, c.density_accept,
			c.mask_draw, c.density_draw, c.pos_z, c.pos_y, c.pos_x});
		do @(posedge clk); while (!s_tready);
		sb.note_candidate(c);
	endtask

	task automatic idle_gap(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// hold the input low until every outstanding result has been taken
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] which, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(which, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int unsigned lim, input int unsigned sp, input bit loc,
			input bit den, input bit msk);
		drain();
		apb_write(REG_MAX_ACCEPTED, lim);
		apb_write(REG_DEFAULT_SP, sp);
		apb_write(REG_USE_LOCAL_SP, 32'(loc));
		apb_write(REG_USE_DENSITY, 32'(den));
		apb_write(REG_USE_MASK, 32'(msk));
	endtask

	task automatic run_phase(input int count, input int hold_at, input int drain_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_request = LONG_HOLD;
			if (i == drain_at)
				drain();
			if (!calm && $urandom_range(0, 7) == 0)
				idle_gap($urandom_range(1, 8));
			send_item(random_candidate(i == 0));
		end
	endtask

	initial begin
		candidate_t c;
		sb = new;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// spacing 1.0 from the default register, both gates on, limit of three
		set_config(3, 4096, 0, 1, 1);
		send_item(make_item(1, 0, 0, 0, 0, 0, PROB_ONE, PROB_ONE, 0));
		send_item(make_item(0, 4095, 0, 0, 0, 0, PROB_ONE, PROB_ONE, 0));
		send_item(make_item(0, 4096, 0, 0, 0, 0, PROB_ONE, PROB_ONE, 0));
		send_item(make_item(0, 9000, 9000, 0, 65535, 0, 65535, PROB_ONE, 0));
		send_item(make_item(0, 9000, 9000, 0, 65535, 100, 131071, 100, 0));
		send_item(make_item(0, 9000, 9000, 0, 0, 0, 0, PROB_ONE, 0));
		send_item(make_item(0, -2365, -2365, -2365, 0, 0, PROB_ONE, PROB_ONE, 0));
		send_item(make_item(0, 20000, 20000, 20000, 0, 0, PROB_ONE, PROB_ONE, 0));
		send_item(make_item(1, -8388608, 8388607, -8388608, 0, 0, PROB_ONE, PROB_ONE, 0));
		send_item(make_item(0, 8388607, -8388608, 8388607, 0, 0, PROB_ONE, PROB_ONE, 0));

		// per-candidate spacing, gates off, limit above the store size
		set_config(2047, 4096, 1, 0, 0);
		send_item(make_item(1, 0, 0, 0, 0, 0, PROB_ONE, PROB_ONE, 0));
		send_item(make_item(0, 0, 0, 0, 65535, 65535, PROB_ONE, PROB_ONE, 8388607));
		send_item(make_item(0, 8388607, 8388607, 8388607, 0, 0, PROB_ONE, PROB_ONE, 1));
		send_item(make_item(0, 8388606, 0, 0, 0, 0, PROB_ONE, PROB_ONE, 1));
		send_item(make_item(0, -8388608, -8388608, -8388608, 65535, 65535, 0, 0, 5));

		// zero limit takes precedence over a zero spacing
		set_config(0, 4096, 1, 1, 1);
		send_item(make_item(1, 0, 0, 0, 0, 0, PROB_ONE, PROB_ONE, 4096));
		send_item(make_item(0, 0, 0, 0, 0, 0, PROB_ONE, PROB_ONE, 0));

		// short density-reject run on a fresh batch
		calm = 1'b1;
		set_config(1024, 4096, 0, 1, 0);
		for (int i = 0; i < 8; i++) begin
			c = random_candidate(i == 0);
			c.new_batch = (i == 0);
			c.density_accept = '0;
			send_item(c);
		end
		calm = 1'b0;

		set_config(1024, 4096, 1, 1, 1);
		run_phase(95, 40, -1);
		set_config(5, 1, 0, 0, 1);
		run_phase(95, -1, -1);
		set_config(1023, 8388607, 0, 1, 0);
		run_phase(95, -1, 50);
		set_config(2047, 12000, 1, 0, 0);
		run_phase(95, 30, -1);
		set_config(1, 4096, 1, 1, 1);
		run_phase(95, -1, -1);
		calm = 1'b1;
		set_config(1024, 6000, 1, 1, 1);
		run_phase(95, -1, -1);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pdrf_pkg.sv
rtl/pdrf_scan.sv
rtl/poisson_disk_rejection_filter_core.sv
test/tb_poisson_disk_rejection_filter_core.sv
